[rtl/core/kca_pkg.sv]
// ----------------------------------------------------------------------------
// kca_pkg: shared types and constants for the k-means centroid accumulator
// Operation codes, register indexes, field widths and FSM encoding.
// ----------------------------------------------------------------------------
package kca_pkg;

	// default sizing
	localparam int DEF_MAX_CLUSTERS = 256;
	localparam int DEF_MAX_DIM      = 128;

	// field widths
	localparam int VAL_W  = 32;  // sample / mean, Q16.16
	localparam int WFLD_W = 16;  // sample weight, Q8.8
	localparam int SUM_W  = 48;  // accumulated sum, units 2^-24
	localparam int WGT_W  = 32;  // cluster weight, units 2^-8
	localparam int CFG_W  = 9;   // config write data
	localparam int MCNT_W = $clog2(WFLD_W + 1);
	localparam int DCNT_W = $clog2(SUM_W + 1);

	// one sample counts as 1.0 in Q8.8
	localparam logic [WFLD_W-1:0] UNIT_WEIGHT = WFLD_W'(256);

	// operation codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ACCUM = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;  // unused, changes nothing

	// register indexes
	localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
	localparam logic [1:0] REG_FROZEN_COUNT  = 2'd1;
	localparam logic [1:0] REG_DIM_COUNT     = 2'd2;
	localparam logic [1:0] REG_WEIGHTED_MODE = 2'd3;

	// control state, one-hot
	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_SWEEP = 9'b000000100,
		ST_FETCH = 9'b000001000,
		ST_MUL   = 9'b000010000,
		ST_UPD   = 9'b000100000,
		ST_CHK   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	// handshake between control and a serial arithmetic unit
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;

endpackage

[rtl/core/kca_ram.sv]
// ----------------------------------------------------------------------------
// kca_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/kca_mul.sv]
// ----------------------------------------------------------------------------
// kca_mul: bit-serial signed x unsigned multiplier
// Consumes one weight bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module kca_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kca_pkg::unit_ctl_t                ctl,
	input  logic signed [kca_pkg::VAL_W-1:0]  mcand,
	input  logic [kca_pkg::WFLD_W-1:0]        mplier,
	output kca_pkg::unit_sts_t                sts,
	output logic signed [kca_pkg::SUM_W-1:0]  product
);

	logic                              run_q;
	logic                              done_q;
	logic [kca_pkg::MCNT_W-1:0]        cnt_q;
	logic signed [kca_pkg::SUM_W-1:0]  acc_q;
	logic signed [kca_pkg::SUM_W-1:0]  mcand_q;
	logic [kca_pkg::WFLD_W-1:0]        wsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= kca_pkg::MCNT_W'(kca_pkg::WFLD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == kca_pkg::MCNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q   <= '0;
			mcand_q <= kca_pkg::SUM_W'(mcand);
			wsh_q   <= mplier;
		end else if (run_q) begin
			if (wsh_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
			wsh_q   <= wsh_q >> 1;
		end
	end

	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

[rtl/core/kca_div.sv]
// ----------------------------------------------------------------------------
// kca_div: bit-serial restoring divider
// Unsigned 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kca_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kca_pkg::unit_ctl_t          ctl,
	input  logic [kca_pkg::SUM_W-1:0]   dividend,
	input  logic [kca_pkg::WGT_W-1:0]   divisor,
	output kca_pkg::unit_sts_t          sts,
	output logic [kca_pkg::SUM_W-1:0]   quotient
);

	logic                         run_q;
	logic                         done_q;
	logic [kca_pkg::DCNT_W-1:0]   cnt_q;
	logic [kca_pkg::WGT_W-1:0]    rem_q;
	logic [kca_pkg::SUM_W-1:0]    quo_q;
	logic [kca_pkg::WGT_W-1:0]    dvs_q;
	logic [kca_pkg::WGT_W:0]      trial;
	logic [kca_pkg::WGT_W:0]      diff;

	// one restoring step
	assign trial = {rem_q, quo_q[kca_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= kca_pkg::DCNT_W'(kca_pkg::SUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == kca_pkg::DCNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[kca_pkg::WGT_W]) begin
				rem_q <= diff[kca_pkg::WGT_W-1:0];
				quo_q <= {quo_q[kca_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[kca_pkg::WGT_W-1:0];
				quo_q <= {quo_q[kca_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/kmeans_centroid_accumulator_top.sv]
// ----------------------------------------------------------------------------
// kmeans_centroid_accumulator_top: k-means centroid update engine
// Per-cluster weighted sums and weights; clear, accumulate and mean read.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | operation cluster dim sample_value weight
//          |                       | first_of_vector
//  out     | out_valid / out_stall | centroid_mean empty_cluster dropped
//          |                       | saturated
//  cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
//  Accumulate: paced by the bit-serial multiplier (16 steps).
//  Read: paced by the bit-serial divider (48 steps).
//  Clear: one entry per cycle, all MAX_DIM dims of every unfrozen cluster.
//  Rejected and unused operations go straight from idle to the result state.
//  After reset a clearing pass over all MAX_CLUSTERS * MAX_DIM entries zeroes
//  both memories; no transaction is accepted until it ends.
//  A stalled result sits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module kmeans_centroid_accumulator_top #(
	parameter int MAX_CLUSTERS = kca_pkg::DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = kca_pkg::DEF_MAX_DIM
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic signed [9:0]                 cluster,
	input  logic [6:0]                        dim,
	input  logic signed [kca_pkg::VAL_W-1:0]  sample_value,
	input  logic [kca_pkg::WFLD_W-1:0]        weight,
	input  logic                              first_of_vector,
	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [kca_pkg::VAL_W-1:0]  centroid_mean,
	output logic                              empty_cluster,
	output logic                              dropped,
	output logic                              saturated,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [kca_pkg::CFG_W-1:0]         cfg_data
);

	localparam int KW    = $clog2(MAX_CLUSTERS + 1);
	localparam int CMPW  = ((KW > 10) ? KW : 10) + 1;
	localparam int DKW   = $clog2(MAX_DIM + 1);
	localparam int DCW   = ((DKW > 8) ? DKW : 8) + 1;
	localparam int CIW   = $clog2(MAX_CLUSTERS);
	localparam int DIW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_CLUSTERS * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = kca_pkg::SUM_W;
	localparam int WW    = kca_pkg::WGT_W;
	localparam int VW    = kca_pkg::VAL_W;

	// entry address of a cluster/dimension pair
	function automatic logic [AW-1:0] entry_addr(logic [CIW-1:0] c, logic [DIW-1:0] d);
		entry_addr = AW'(c) * AW'(MAX_DIM) + AW'(d);
	endfunction

	kca_pkg::state_t state_q;

	// configuration registers
	logic [8:0] cluster_count_q;
	logic [8:0] frozen_count_q;
	logic [7:0] dim_count_q;
	logic       weighted_mode_q;

	// effective counts and index checks
	logic [CMPW-1:0] kc, fc, cl_ext, sc_q, swe_q;
	logic [DCW-1:0]  kd, dm_ext;
	logic            cl_neg, cl_in, dm_in, acc_ok, rd_ok;

	// latched item
	logic [CIW-1:0]  cl_idx_q;
	logic [AW-1:0]   addr_q;
	logic [1:0]      op_q;
	logic            first_q;
	logic [kca_pkg::WFLD_W-1:0] w_q;

	// sweep dimension counter
	logic [DIW-1:0]  sd_q;

	// result being built
	logic [VW-1:0]   res_mean_q;
	logic            res_empty_q, res_drop_q, res_sat_q;

	// output register
	logic            out_valid_q;
	logic [VW-1:0]   out_mean_q;
	logic            out_empty_q, out_drop_q, out_sat_q;

	// memories
	logic            sum_we, wgt_we;
	logic [AW-1:0]   sum_waddr;
	logic [CIW-1:0]  wgt_waddr;
	logic [SW-1:0]   sum_wdata, sum_rdata;
	logic [WW-1:0]   wgt_wdata, wgt_rdata;

	// serial units
	kca_pkg::unit_ctl_t mul_ctl, div_ctl;
	kca_pkg::unit_sts_t mul_sts, div_sts;
	logic signed [SW-1:0] product;
	logic [SW-1:0]        dvd_mag, quo;
	logic [kca_pkg::WFLD_W-1:0] w_eff;

	// accumulate update
	logic [SW:0]     sum_ext;
	logic            sum_ovf;
	logic [SW-1:0]   sum_new;
	logic [WW:0]     wgt_ext;

	// read finish
	logic            sum_neg_q;
	logic            q_big;
	logic [VW-1:0]   q_signed;

	logic            in_acc, out_acc, out_load;

	// ---------------- index checks ----------------
	assign kc = (CMPW'(cluster_count_q) < CMPW'(MAX_CLUSTERS)) ?
		CMPW'(cluster_count_q) : CMPW'(MAX_CLUSTERS);
	assign fc = CMPW'(frozen_count_q);
	assign kd = (DCW'(dim_count_q) < DCW'(MAX_DIM)) ? DCW'(dim_count_q) : DCW'(MAX_DIM);
	assign cl_neg = cluster[9];
	assign cl_ext = CMPW'(cluster[8:0]);
	assign dm_ext = DCW'(dim);
	assign cl_in  = !cl_neg && (cl_ext < kc);
	assign dm_in  = dm_ext < kd;
	assign rd_ok  = cl_in && dm_in;
	assign acc_ok = rd_ok && (cl_ext >= fc);
	assign w_eff  = weighted_mode_q ? weight : kca_pkg::UNIT_WEIGHT;

	// ---------------- handshakes ----------------
	assign in_stall  = (state_q != kca_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_load  = (state_q == kca_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= 9'd256;
			frozen_count_q  <= 9'd0;
			dim_count_q     <= 8'd128;
			weighted_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kca_pkg::REG_CLUSTER_COUNT: cluster_count_q <= cfg_data;
				kca_pkg::REG_FROZEN_COUNT:  frozen_count_q  <= cfg_data;
				kca_pkg::REG_DIM_COUNT:     dim_count_q     <= cfg_data[7:0];
				kca_pkg::REG_WEIGHTED_MODE: weighted_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- arithmetic units ----------------
	assign mul_ctl.start = in_acc && (operation == kca_pkg::OP_ACCUM) && acc_ok;
	assign div_ctl.start = (state_q == kca_pkg::ST_CHK) && (wgt_rdata != '0);
	assign dvd_mag = sum_rdata[SW-1] ? (~sum_rdata + 1'b1) : sum_rdata;

	kca_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.mcand   (sample_value),
		.mplier  (w_eff),
		.sts     (mul_sts),
		.product (product)
	);

	kca_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dvd_mag),
		.divisor  (wgt_rdata),
		.sts      (div_sts),
		.quotient (quo)
	);

	// saturating sum and weight update
	assign sum_ext = {sum_rdata[SW-1], sum_rdata} + {product[SW-1], product};
	assign sum_ovf = sum_ext[SW] != sum_ext[SW-1];
	assign sum_new = sum_ovf ? (sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
		: sum_ext[SW-1:0];
	assign wgt_ext = {1'b0, wgt_rdata} + (WW+1)'(w_q);

	// quotient sign and clip
	assign q_big = sum_neg_q ?
		((quo[SW-1:VW-1] != '0) && (quo != (SW'(1) << (VW-1)))) :
		(quo[SW-1:VW-1] != '0);
	assign q_signed = sum_neg_q ? (~quo[VW-1:0] + 1'b1) : quo[VW-1:0];

	// ---------------- memory ports ----------------
	always_comb begin
		sum_we    = 1'b0;
		wgt_we    = 1'b0;
		sum_waddr = addr_q;
		wgt_waddr = cl_idx_q;
		sum_wdata = sum_new;
		wgt_wdata = wgt_ext[WW] ? {WW{1'b1}} : wgt_ext[WW-1:0];
		if (state_q == kca_pkg::ST_INIT || state_q == kca_pkg::ST_SWEEP) begin
			sum_we    = 1'b1;
			wgt_we    = (sd_q == '0);
			sum_waddr = entry_addr(sc_q[CIW-1:0], sd_q);
			wgt_waddr = sc_q[CIW-1:0];
			sum_wdata = '0;
			wgt_wdata = '0;
		end else if (state_q == kca_pkg::ST_UPD) begin
			sum_we = 1'b1;
			wgt_we = first_q;
		end
	end

	kca_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (addr_q),
		.rdata (sum_rdata)
	);

	kca_ram #(.WIDTH(WW), .DEPTH(MAX_CLUSTERS)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (wgt_wdata),
		.raddr (cl_idx_q),
		.rdata (wgt_rdata)
	);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kca_pkg::ST_INIT;
			sc_q    <= '0;
			sd_q    <= '0;
			swe_q   <= CMPW'(MAX_CLUSTERS);
		end else begin
			unique case (state_q)
				kca_pkg::ST_INIT, kca_pkg::ST_SWEEP: begin
					if (sd_q == DIW'(MAX_DIM - 1)) begin
						sd_q <= '0;
						sc_q <= sc_q + 1'b1;
						if (sc_q + 1'b1 == swe_q) begin
							state_q <= (state_q == kca_pkg::ST_INIT) ?
								kca_pkg::ST_IDLE : kca_pkg::ST_DONE;
						end
					end else begin
						sd_q <= sd_q + 1'b1;
					end
				end
				kca_pkg::ST_IDLE: begin
					if (in_acc) begin
						priority if (operation == kca_pkg::OP_CLEAR) begin
							sc_q    <= fc;
							sd_q    <= '0;
							swe_q   <= kc;
							state_q <= (fc < kc) ? kca_pkg::ST_SWEEP : kca_pkg::ST_DONE;
						end else if (operation == kca_pkg::OP_ACCUM && acc_ok) begin
							state_q <= kca_pkg::ST_FETCH;
						end else if (operation == kca_pkg::OP_READ && rd_ok) begin
							state_q <= kca_pkg::ST_FETCH;
						end else begin
							state_q <= kca_pkg::ST_DONE;
						end
					end
				end
				kca_pkg::ST_FETCH: begin
					state_q <= (op_q == kca_pkg::OP_ACCUM) ? kca_pkg::ST_MUL : kca_pkg::ST_CHK;
				end
				kca_pkg::ST_MUL: begin
					if (mul_sts.done) begin
						state_q <= kca_pkg::ST_UPD;
					end
				end
				kca_pkg::ST_UPD: begin
					state_q <= kca_pkg::ST_DONE;
				end
				kca_pkg::ST_CHK: begin
					state_q <= (wgt_rdata == '0) ? kca_pkg::ST_DONE : kca_pkg::ST_DIV;
				end
				kca_pkg::ST_DIV: begin
					if (div_sts.done) begin
						state_q <= kca_pkg::ST_DONE;
					end
				end
				kca_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= kca_pkg::ST_IDLE;
					end
				end
				default: state_q <= kca_pkg::ST_IDLE;
			endcase
		end
	end

	// ---------------- item and result payload ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q        <= operation;
			first_q     <= first_of_vector;
			w_q         <= w_eff;
			cl_idx_q    <= cl_ext[CIW-1:0];
			addr_q      <= entry_addr(cl_ext[CIW-1:0], dm_ext[DIW-1:0]);
			res_mean_q  <= '0;
			res_empty_q <= 1'b0;
			res_sat_q   <= 1'b0;
			res_drop_q  <= (operation == kca_pkg::OP_ACCUM && !acc_ok) ||
				(operation == kca_pkg::OP_READ && !rd_ok);
		end
		if (state_q == kca_pkg::ST_UPD) begin
			res_sat_q <= sum_ovf || (first_q && wgt_ext[WW]);
		end
		if (state_q == kca_pkg::ST_CHK) begin
			res_empty_q <= (wgt_rdata == '0);
			sum_neg_q   <= sum_rdata[SW-1];
		end
		if (state_q == kca_pkg::ST_DIV && div_sts.done) begin
			res_sat_q  <= q_big;
			res_mean_q <= q_big ? (sum_neg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
				: q_signed;
		end
		if (out_load) begin
			out_mean_q  <= res_mean_q;
			out_empty_q <= res_empty_q;
			out_drop_q  <= res_drop_q;
			out_sat_q   <= res_sat_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign centroid_mean = out_mean_q;
	assign empty_cluster = out_empty_q;
	assign dropped       = out_drop_q;
	assign saturated     = out_sat_q;

endmodule
